/* hw/rtl/alloc_trace_pair_filter_defines.svh */
// ----------------------------------------------------------------------------
// alloc trace pair filter assertion macros
// shared concurrent check forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ALLOC_TRACE_PAIR_FILTER_DEFINES_SVH
`define ALLOC_TRACE_PAIR_FILTER_DEFINES_SVH

// same-cycle implication
`define ATPF_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("atpf check failed");

// next-cycle implication
`define ATPF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("atpf check failed");

`endif

/* hw/rtl/atpf_pkg.sv */
// ----------------------------------------------------------------------------
// atpf_pkg
// shared widths, command codes and slot types of the alloc trace pair filter
// ----------------------------------------------------------------------------
`default_nettype none

package atpf_pkg;

   localparam int CMD_W          = 2;
   localparam int FIELD_W        = 48;
   localparam int DEF_RING_DEPTH = 16;
   localparam int DEF_ADDR_BITS  = 48;

   // command codes, also used as the stored and emitted kind
   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REALLOC = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]   kind;
      logic [FIELD_W-1:0] address;
      logic [FIELD_W-1:0] old_address;
      logic [FIELD_W-1:0] size;
   } slot_type;

   typedef struct packed {
      logic     live;
      slot_type slot;
   } rd_type;

endpackage

`default_nettype wire

/* hw/rtl/atpf_req_if.sv */
// ----------------------------------------------------------------------------
// atpf_req_if
// event item channel: valid, ready and the event fields
// ----------------------------------------------------------------------------
`default_nettype none

interface atpf_req_if
   import atpf_pkg::*;
   ();

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [FIELD_W-1:0] address;
   logic [FIELD_W-1:0] old_address;
   logic [FIELD_W-1:0] size;

   modport source (output valid, command, address, old_address, size, input ready);
   modport sink   (input valid, command, address, old_address, size, output ready);
   modport mon    (input valid, ready, command, address, old_address, size);

endinterface

`default_nettype wire

/* hw/rtl/atpf_rsp_if.sv */
// ----------------------------------------------------------------------------
// atpf_rsp_if
// emitted event item channel: valid, ready and the event fields
// ----------------------------------------------------------------------------
`default_nettype none

interface atpf_rsp_if
   import atpf_pkg::*;
   ();

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   kind;
   logic [FIELD_W-1:0] out_address;
   logic [FIELD_W-1:0] out_old_address;
   logic [FIELD_W-1:0] out_size;

   modport source (output valid, kind, out_address, out_old_address, out_size, input ready);
   modport sink   (input valid, kind, out_address, out_old_address, out_size, output ready);
   modport mon    (input valid, ready, kind, out_address, out_old_address, out_size);

endinterface

`default_nettype wire

/* hw/rtl/atpf_ring.sv */
// ----------------------------------------------------------------------------
// atpf_ring
// slot memory of the delay ring with one write and one registered read port,
// plus a live flag per slot cleared by reset
// ----------------------------------------------------------------------------
`default_nettype none

module atpf_ring
   import atpf_pkg::*;
#(
   parameter int RING_DEPTH = DEF_RING_DEPTH,
   localparam int IDX_W = $clog2(RING_DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [IDX_W-1:0] rd_idx,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_idx,
   input  wire slot_type         wr_slot,
   input  wire logic             clr_en,
   input  wire logic [IDX_W-1:0] clr_idx,
   output rd_type                rd
);

   slot_type                mem [RING_DEPTH];
   logic [RING_DEPTH-1:0]   live_ff, live_in;
   logic                    rd_live_ff;
   slot_type                rd_slot_ff;

   always_comb begin
      live_in = live_ff;
      if (clr_en) begin
         live_in[clr_idx] = 1'b0;
      end
      if (wr_en) begin
         live_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff    <= '0;
         rd_live_ff <= 1'b0;
      end else begin
         live_ff    <= live_in;
         rd_live_ff <= live_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_slot;
      end
      rd_slot_ff <= mem[rd_idx];
   end

   assign rd.live = rd_live_ff;
   assign rd.slot = rd_slot_ff;

endmodule

`default_nettype wire

/* hw/rtl/atpf_seq.sv */
// ----------------------------------------------------------------------------
// atpf_seq
// sequencer: takes an event; for a free of a nonzero address, walks the ring
// newest to oldest through the one address comparator; then, unless a pair was
// cancelled or the event dropped, emits the victim slot and writes the event
`default_nettype none

module atpf_seq
   import atpf_pkg::*;
#(
   parameter int RING_DEPTH = DEF_RING_DEPTH,
   parameter int ADDR_BITS  = DEF_ADDR_BITS,
   localparam int IDX_W = $clog2(RING_DEPTH)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [CMD_W-1:0]   req_command,
   input  wire logic [FIELD_W-1:0] req_address,
   input  wire logic [FIELD_W-1:0] req_old_address,
   input  wire logic [FIELD_W-1:0] req_size,
   input  wire rd_type             rd,
   output logic [IDX_W-1:0]        rd_idx,
   output logic                    wr_en,
   output logic [IDX_W-1:0]        wr_idx,
   output slot_type                wr_slot,
   output logic                    clr_en,
   output logic [IDX_W-1:0]        clr_idx,
   input  wire logic               out_free,
   output logic                    emit_en
);

   localparam int AW = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
   localparam logic [FIELD_W-1:0] ADDR_MASK = {FIELD_W{1'b1}} >> (FIELD_W - AW);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(RING_DEPTH - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_POS_RD = 3'd2;
   localparam logic [2:0] ST_EMIT   = 3'd3;
   localparam logic [2:0] ST_WRITE  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   prev_ff, prev_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   slot_type           slot_ff, slot_in;
   logic [FIELD_W-1:0] req_addr_m;
   logic               addr_hit;

   function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] i);
      return (i == '0) ? LAST : IDX_W'(i - 1'b1);
   endfunction

   function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] i);
      return (i == LAST) ? '0 : IDX_W'(i + 1'b1);
   endfunction

   assign req_addr_m = req_address & ADDR_MASK;
   // the shared compare unit
   assign addr_hit   = rd.live && (rd.slot.address == slot_ff.address);
   assign req_ready  = (state_ff == ST_IDLE);
   assign wr_idx     = pos_ff;
   assign wr_slot    = slot_ff;

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      idx_in   = idx_ff;
      prev_in  = prev_ff;
      cnt_in   = cnt_ff;
      pend_in  = pend_ff;
      slot_in  = slot_ff;
      rd_idx   = pos_ff;
      wr_en    = 1'b0;
      clr_en   = 1'b0;
      clr_idx  = prev_ff;
      emit_en  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               slot_in.kind        = req_command;
               slot_in.address     = req_addr_m;
               slot_in.old_address = (req_command == CMD_REALLOC)
                                     ? (req_old_address & ADDR_MASK) : '0;
               slot_in.size        = (req_command == CMD_FREE) ? '0 : req_size;
               case (req_command) inside
                  CMD_ALLOC, CMD_REALLOC: begin
                     state_in = ST_POS_RD;
                  end
                  CMD_FREE: begin
                     if (req_addr_m != '0) begin
                        idx_in   = ring_dec(pos_ff);
                        cnt_in   = '0;
                        pend_in  = 1'b0;
                        state_in = ST_SEARCH;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            rd_idx  = idx_ff;
            idx_in  = ring_dec(idx_ff);
            prev_in = idx_ff;
            pend_in = 1'b1;
            if (pend_ff) begin
               cnt_in = IDX_W'(cnt_ff + 1'b1);
               if (addr_hit) begin
                  pend_in = 1'b0;
                  if (rd.slot.kind == CMD_ALLOC) begin
                     clr_en   = 1'b1;
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_POS_RD;
                  end
               end else if (cnt_ff == LAST) begin
                  pend_in  = 1'b0;
                  state_in = ST_POS_RD;
               end
            end
         end
         ST_POS_RD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rd.live) begin
               state_in = ST_WRITE;
            end else if (out_free) begin
               emit_en  = 1'b1;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            wr_en    = 1'b1;
            pos_in   = ring_inc(pos_ff);
            state_in = ST_IDLE;
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      prev_ff <= prev_in;
      cnt_ff  <= cnt_in;
      slot_ff <= slot_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/alloc_trace_pair_filter.sv */
// ----------------------------------------------------------------------------
// alloc_trace_pair_filter
// delay ring of recent allocation events that cancels alloc/free pairs
// ----------------------------------------------------------------------------
// One item at a time. An alloc or realloc reads the slot at the write position,
// emits it if live, then writes the event; a free of a nonzero address
// walks the ring newest to oldest, one slot per cycle through the single
// read port of the slot memory, until a match stops the walk or every slot
// is read; a free of address 0 or command 3 is dropped. A victim item waits
// in the result register while the result channel stalls; the block holds
// its write until that register is free. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module alloc_trace_pair_filter
   import atpf_pkg::*;
#(
   parameter int RING_DEPTH = DEF_RING_DEPTH,
   parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
   input  wire logic  clock,
   input  wire logic  reset,
   atpf_req_if.sink   req_chan,
   atpf_rsp_if.source rsp_chan
);

   localparam int IDX_W = $clog2(RING_DEPTH);

   rd_type           rd;
   logic [IDX_W-1:0] rd_idx;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   slot_type         wr_slot;
   logic             clr_en;
   logic [IDX_W-1:0] clr_idx;
   logic             emit_en;
   logic             out_free;
   logic             rsp_valid_ff, rsp_valid_in;
   slot_type         rsp_slot_ff;

   atpf_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (rd_idx),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_slot (wr_slot),
      .clr_en  (clr_en),
      .clr_idx (clr_idx),
      .rd      (rd)
   );

   atpf_seq #(
      .RING_DEPTH (RING_DEPTH),
      .ADDR_BITS  (ADDR_BITS)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_command     (req_chan.command),
      .req_address     (req_chan.address),
      .req_old_address (req_chan.old_address),
      .req_size        (req_chan.size),
      .rd              (rd),
      .rd_idx          (rd_idx),
      .wr_en           (wr_en),
      .wr_idx          (wr_idx),
      .wr_slot         (wr_slot),
      .clr_en          (clr_en),
      .clr_idx         (clr_idx),
      .out_free        (out_free),
      .emit_en         (emit_en)
   );

   // result register
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_en) begin
         rsp_slot_ff <= rd.slot;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.kind            = rsp_slot_ff.kind;
   assign rsp_chan.out_address     = rsp_slot_ff.address;
   assign rsp_chan.out_old_address = rsp_slot_ff.old_address;
   assign rsp_chan.out_size        = rsp_slot_ff.size;

endmodule

`default_nettype wire

/* hw/rtl/atpf_checker.sv */
// ----------------------------------------------------------------------------
// atpf_checker
// port-level checks of the alloc trace pair filter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "alloc_trace_pair_filter_defines.svh"

module atpf_checker
   import atpf_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [CMD_W-1:0]   rsp_kind,
   input wire logic [FIELD_W-1:0] rsp_out_address,
   input wire logic [FIELD_W-1:0] rsp_out_old_address,
   input wire logic [FIELD_W-1:0] rsp_out_size
);

   localparam logic [CMD_W-1:0] KIND_NONE = 2'd3;

   logic                           rsp_free;
   logic                           rsp_alloc;
   logic [CMD_W+3*FIELD_W-1:0]     rsp_payload;

   assign rsp_free    = rsp_valid && (rsp_kind == CMD_FREE);
   assign rsp_alloc   = rsp_valid && (rsp_kind == CMD_ALLOC);
   assign rsp_payload = {rsp_kind, rsp_out_address, rsp_out_old_address, rsp_out_size};

   `ATPF_ASSERT_NOW(a_kind_known, rsp_valid, rsp_kind != KIND_NONE)
   `ATPF_ASSERT_NOW(a_free_zeroed, rsp_free, (rsp_out_size == '0) && (rsp_out_old_address == '0))
   `ATPF_ASSERT_NOW(a_alloc_no_old, rsp_alloc, rsp_out_old_address == '0)
   `ATPF_ASSERT_NEXT(a_busy_after_item, req_valid && req_ready, !req_ready)
   `ATPF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

endmodule

bind alloc_trace_pair_filter atpf_checker u_atpf_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_kind            (rsp_chan.kind),
   .rsp_out_address     (rsp_chan.out_address),
   .rsp_out_old_address (rsp_chan.out_old_address),
   .rsp_out_size        (rsp_chan.out_size)
);

`default_nettype wire

/* dv/alloc_trace_pair_filter_tb.sv */
// ----------------------------------------------------------------------------
// alloc_trace_pair_filter_tb
// self-checking bench: drives alloc, free and realloc events, mirrors the
// delay ring in a local predictor and checks every emitted item against it
// ----------------------------------------------------------------------------
`default_nettype none

module alloc_trace_pair_filter_tb;
   import atpf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING = DEF_RING_DEPTH;
   localparam int POOL = 32;
   localparam int HOLD_CYCLES = 300;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      SLOT_EMPTY,
      SLOT_ALLOC,
      SLOT_REALLOC,
      SLOT_FREE
   } slot_state_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [FIELD_W-1:0] address;
      logic [FIELD_W-1:0] old_address;
      logic [FIELD_W-1:0] size;
   } trace_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   atpf_req_if req_if ();
   atpf_rsp_if rsp_if ();

   alloc_trace_pair_filter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #6 clock = ~clock;

   trace_event_type    event_q[$];
   slot_type           victim_q[$];
   logic [FIELD_W-1:0] live_allocs[$];
   logic [FIELD_W-1:0] addr_pool[POOL];

   slot_state_type     ring_kind[RING];
   logic [FIELD_W-1:0] ring_addr[RING];
   logic [FIELD_W-1:0] ring_old[RING];
   logic [FIELD_W-1:0] ring_size[RING];
   int unsigned        wr_ptr;

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  recv_hold = 1'b0;
   bit  hold_armed = 1'b0;
   int  mismatches = 0;
   int  items_accepted = 0;
   int  results_checked = 0;
   int  pairs_cancelled = 0;
   int  items_ignored = 0;

   initial begin
      req_if.valid       = 1'b0;
      req_if.command     = CMD_ALLOC;
      req_if.address     = '0;
      req_if.old_address = '0;
      req_if.size        = '0;
      rsp_if.ready       = 1'b0;
   end

   // ring predictor: updates the local ring and queues any evicted item
   function automatic void ring_step(input trace_event_type ev);
      logic [FIELD_W-1:0] a;
      logic [FIELD_W-1:0] o;
      logic [FIELD_W-1:0] s;
      slot_state_type     k;
      slot_type           victim;
      int unsigned        idx;
      bit                 absorbed;
      a = ev.address;
      o = ev.old_address;
      s = ev.size;
      k = SLOT_EMPTY;
      absorbed = 1'b0;
      case (ev.command)
         CMD_ALLOC: begin
            k = SLOT_ALLOC;
            o = '0;
         end
         CMD_REALLOC: begin
            k = SLOT_REALLOC;
         end
         CMD_FREE: begin
            if (a == '0) begin
               items_ignored++;
               return;
            end
            k = SLOT_FREE;
            o = '0;
            s = '0;
            idx = wr_ptr;
            for (int c = 0; c < RING; c++) begin
               idx = (idx == 0) ? RING - 1 : idx - 1;
               if (ring_addr[idx] == a) begin
                  if (ring_kind[idx] == SLOT_ALLOC) begin
                     ring_kind[idx] = SLOT_EMPTY;
                     ring_addr[idx] = '0;
                     absorbed = 1'b1;
                  end
                  break;
               end
            end
            if (absorbed) begin
               pairs_cancelled++;
               return;
            end
         end
         default: begin
            items_ignored++;
            return;
         end
      endcase
      if (ring_kind[wr_ptr] != SLOT_EMPTY) begin
         case (ring_kind[wr_ptr])
            SLOT_FREE:    victim.kind = CMD_FREE;
            SLOT_REALLOC: victim.kind = CMD_REALLOC;
            default:      victim.kind = CMD_ALLOC;
         endcase
         victim.address     = ring_addr[wr_ptr];
         victim.old_address = ring_old[wr_ptr];
         victim.size        = ring_size[wr_ptr];
         victim_q.push_back(victim);
      end
      ring_kind[wr_ptr] = k;
      ring_addr[wr_ptr] = a;
      ring_old[wr_ptr]  = o;
      ring_size[wr_ptr] = s;
      wr_ptr = (wr_ptr == RING - 1) ? 0 : wr_ptr + 1;
   endfunction

   function automatic void check_field(input string name, input logic [FIELD_W-1:0] want,
                                       input logic [FIELD_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic logic [FIELD_W-1:0] random_word();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(5))
         0: v = v & 64'hFFFF;
         1: v = '1;
         2: v = v >> $urandom_range(47, 16);
         default: ;
      endcase
      return v[FIELD_W-1:0];
   endfunction

   function automatic logic [FIELD_W-1:0] fresh_address();
      int p;
      p = $urandom_range(POOL - 1);
      if ($urandom_range(7) == 0) begin
         addr_pool[p] = random_word();
      end
      if ($urandom_range(1)) begin
         return addr_pool[p];
      end
      return random_word();
   endfunction

   function automatic void push_event(input logic [CMD_W-1:0] cmd,
                                      input logic [FIELD_W-1:0] a,
                                      input logic [FIELD_W-1:0] o,
                                      input logic [FIELD_W-1:0] s);
      trace_event_type ev;
      ev.command     = cmd;
      ev.address     = a;
      ev.old_address = o;
      ev.size        = s;
      event_q.push_back(ev);
   endfunction

   // mostly alloc/free/realloc traffic over reused addresses, some noise
   task automatic queue_traffic(input int count);
      trace_event_type ev;
      int              pick;
      int              idx;
      for (int n = 0; n < count; n++) begin
         ev.command     = CMD_ALLOC;
         ev.address     = '0;
         ev.old_address = '0;
         ev.size        = random_word();
         pick = $urandom_range(99);
         if (pick < 38) begin
            ev.address = fresh_address();
            if ($urandom_range(3) == 0) ev.old_address = random_word();
            live_allocs.push_back(ev.address);
            if (live_allocs.size() > 12) void'(live_allocs.pop_front());
         end else if (pick < 62 && live_allocs.size() != 0) begin
            ev.command = CMD_FREE;
            idx = $urandom_range(live_allocs.size() - 1);
            ev.address = live_allocs[idx];
            live_allocs.delete(idx);
            if ($urandom_range(1)) ev.size = '0;
         end else if (pick < 75) begin
            ev.command = CMD_REALLOC;
            if (live_allocs.size() != 0) begin
               idx = $urandom_range(live_allocs.size() - 1);
               ev.old_address = live_allocs[idx];
               live_allocs.delete(idx);
            end else begin
               ev.old_address = random_word();
            end
            ev.address = fresh_address();
            live_allocs.push_back(ev.address);
         end else if (pick < 87) begin
            ev.command = CMD_FREE;
            ev.address = addr_pool[$urandom_range(POOL - 1)];
         end else begin
            case ($urandom_range(3))
               0: ev.command = CMD_FREE;
               1: begin
                  ev.command     = CMD_UNUSED;
                  ev.address     = random_word();
                  ev.old_address = random_word();
               end
               2: begin
                  ev.command     = 2'($urandom_range(3));
                  ev.address     = random_word();
                  ev.old_address = random_word();
               end
               default: ev.command = CMD_ALLOC;
            endcase
         end
         event_q.push_back(ev);
      end
   endtask

   task automatic wait_drained();
      while (event_q.size() != 0 || req_if.valid || victim_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // driver
   always @(posedge clock) begin
      trace_event_type ev;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            ev = event_q.pop_front();
            req_if.valid       <= 1'b1;
            req_if.command     <= ev.command;
            req_if.address     <= ev.address;
            req_if.old_address <= ev.old_address;
            req_if.size        <= ev.size;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      slot_type        want;
      trace_event_type ev;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_checked++;
            if (victim_q.size() == 0) begin
               $error("emitted item with none expected: kind %0d address %h",
                      rsp_if.kind, rsp_if.out_address);
               mismatches++;
            end else begin
               want = victim_q.pop_front();
               check_field("kind", FIELD_W'(want.kind), FIELD_W'(rsp_if.kind));
               check_field("out_address", want.address, rsp_if.out_address);
               check_field("out_old_address", want.old_address, rsp_if.out_old_address);
               check_field("out_size", want.size, rsp_if.out_size);
            end
         end
         if (req_if.valid && req_if.ready) begin
            items_accepted++;
            ev.command     = req_if.command;
            ev.address     = req_if.address;
            ev.old_address = req_if.old_address;
            ev.size        = req_if.size;
            ring_step(ev);
         end
      end
   end

   // long receiver hold-off so the result register fills and input stalls
   initial begin
      wait (hold_armed);
      repeat (20) @(negedge clock);
      recv_hold = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      recv_hold = 1'b0;
   end

   initial begin
      #6_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      for (int i = 0; i < RING; i++) begin
         ring_kind[i] = SLOT_EMPTY;
         ring_addr[i] = '0;
         ring_old[i]  = '0;
         ring_size[i] = '0;
      end
      wr_ptr = 0;
      for (int i = 0; i < POOL; i++) addr_pool[i] = random_word();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 32;
      recv_idle_pct = 59;

      // directed: field extremes, pair cancel, frees hitting realloc and free,
      // ignored items, and enough allocs to wrap the ring and evict
      push_event(CMD_ALLOC, 48'h0000_1000_0010, 48'h5555_5555_5555, '1);
      push_event(CMD_ALLOC, '0, '0, '0);
      push_event(CMD_ALLOC, '1, '1, 48'h1);
      push_event(CMD_REALLOC, 48'h0000_2000_0020, '1, '1);
      push_event(CMD_FREE, 48'h0000_1000_0010, 48'hAAAA_AAAA_AAAA, 48'h77);
      push_event(CMD_FREE, 48'h0000_2000_0020, '0, '0);
      push_event(CMD_FREE, 48'h0000_2000_0020, 48'h1, 48'h1);
      push_event(CMD_FREE, '0, '1, '1);
      push_event(CMD_UNUSED, 48'h0000_3000_0030, '1, '1);
      push_event(CMD_FREE, 48'h0000_0000_0123, '0, '0);
      push_event(CMD_ALLOC, 48'h8000_0000_0000, '0, 48'h40);
      push_event(CMD_REALLOC, 48'h8000_0000_0000, 48'h8000_0000_0000, 48'h80);
      push_event(CMD_FREE, 48'h8000_0000_0000, '0, '0);
      for (int i = 0; i < 12; i++) begin
         push_event(CMD_ALLOC, 48'h0000_4000_0000 + i, 48'(i), 48'h100 + i);
      end
      wait_drained();

      queue_traffic(650);
      wait_drained();

      send_idle_pct = 59;
      recv_idle_pct = 32;
      queue_traffic(650);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_traffic(700);
      hold_armed = 1'b1;
      wait_drained();

      repeat (RING + 8) @(negedge clock);
      if (victim_q.size() != 0) begin
         $error("%0d expected items never emitted", victim_q.size());
         mismatches++;
      end

      $display("run covered %0d events in, %0d evicted items checked,", items_accepted,
               results_checked);
      $display("%0d alloc/free pairs cancelled and %0d events ignored", pairs_cancelled,
               items_ignored);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
